@@ hw/rtl/eegp_pkg.sv @@
// Shared types and constants of the headset packet parser.
// Used by eegp_decode, eegp_burst and the top level; depends on nothing.
package eegp_pkg;

	// Framing and payload codes
	localparam logic [7:0] SYNC_BYTE  = 8'hAA;
	localparam logic [7:0] CODE_QUAL  = 8'h02;
	localparam logic [7:0] CODE_ATT   = 8'h04;
	localparam logic [7:0] CODE_MED   = 8'h05;
	localparam logic [7:0] CODE_POWER = 8'h83;
	localparam logic [7:0] CODE_SKIP  = 8'h80;
	localparam logic [7:0] QUAL_RESET = 8'd200;

	// Default configuration
	localparam int MAX_PAYLOAD_DEF = 32;
	localparam int POWER_BANDS_DEF = 8;

	// Field widths
	localparam int BAND_W = 3;
	localparam int PWR_W  = 24;

	// Result status codes
	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_BAD_SUM  = 2'd2,
		ST_UNKNOWN  = 2'd3
	} status_t;

	// Payload decode phase, one-hot
	typedef enum logic [6:0] {
		PH_CODE  = 7'b0000001,
		PH_QUAL  = 7'b0000010,
		PH_ATT   = 7'b0000100,
		PH_MED   = 7'b0001000,
		PH_PLEN  = 7'b0010000,
		PH_PDATA = 7'b0100000,
		PH_SKIP  = 7'b1000000
	} phase_t;

	// New result run handed from the decoder to the burst stage
	typedef struct packed {
		logic              valid;
		status_t           status;
		logic              has_power;
		logic [7:0]        quality;
		logic [7:0]        attention;
		logic [7:0]        meditation;
		logic [PWR_W-1:0]  power0;
	} run_t;

endpackage

@@ hw/rtl/eegp_decode.sv @@
// Input register, frame tracking, payload decode and commit of the parser.
// Depends on eegp_pkg.
module eegp_decode #(
	parameter int MAX_PAYLOAD = eegp_pkg::MAX_PAYLOAD_DEF,
	parameter int POWER_BANDS = eegp_pkg::POWER_BANDS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [7:0]                 in_byte,
	output logic                       in_ready,
	input  logic                       run_ready,
	output eegp_pkg::run_t             run,
	output logic [eegp_pkg::PWR_W-1:0] pow_cur [POWER_BANDS]
);
	import eegp_pkg::*;

	// input register
	logic             valid_s1;
	logic [7:0]       byte_s1;

	// frame and decode state
	logic             in_frame_q, in_frame_d;
	logic [7:0]       prev_q, prev_d;
	logic [7:0]       pos_q, pos_d;
	logic [7:0]       len_q, len_d;
	logic [7:0]       sum_q, sum_d;
	phase_t           phase_q, phase_d;
	logic [BAND_W-1:0] band_q, band_d;
	logic [1:0]       sub_q, sub_d;
	logic [7:0]       sh_scal_q [3];
	logic [7:0]       sh_scal_d [3];
	logic [2:0]       sh_seen_q, sh_seen_d;
	logic [PWR_W-1:0] sh_pow_q [POWER_BANDS];
	logic [PWR_W-1:0] sh_pow_d [POWER_BANDS];
	logic             sh_pseen_q, sh_pseen_d;
	logic             err_q, err_d;

	// committed values
	logic [7:0]       qual_q, qual_d;
	logic [7:0]       att_q, att_d;
	logic [7:0]       med_q, med_d;
	logic [PWR_W-1:0] pow_q [POWER_BANDS];
	logic [PWR_W-1:0] pow_d [POWER_BANDS];
	logic             present_q, present_d;

	logic             emits;
	logic             adv;
	logic [7:0]       b;

	assign b = byte_s1;

	// a byte that ends a frame waits until the burst stage is free
	assign emits = in_frame_q && ((pos_q == 8'd0) ? (b > 8'(MAX_PAYLOAD)) : (pos_q > len_q));
	assign adv = valid_s1 && (!emits || run_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// next state for one byte
	always_comb begin
		in_frame_d = in_frame_q;
		prev_d     = prev_q;
		pos_d      = pos_q;
		len_d      = len_q;
		sum_d      = sum_q;
		phase_d    = phase_q;
		band_d     = band_q;
		sub_d      = sub_q;
		sh_scal_d  = sh_scal_q;
		sh_seen_d  = sh_seen_q;
		sh_pow_d   = sh_pow_q;
		sh_pseen_d = sh_pseen_q;
		err_d      = err_q;
		qual_d     = qual_q;
		att_d      = att_q;
		med_d      = med_q;
		pow_d      = pow_q;
		present_d  = present_q;
		run        = '0;

		if (adv) begin
			if (in_frame_q) begin
				if (pos_q == 8'd0) begin
					// length byte
					len_d      = b;
					sum_d      = 8'd0;
					phase_d    = PH_CODE;
					band_d     = '0;
					sub_d      = 2'd0;
					sh_seen_d  = 3'b000;
					sh_pseen_d = 1'b0;
					err_d      = 1'b0;
					if (b > 8'(MAX_PAYLOAD)) begin
						in_frame_d = 1'b0;
						run.valid      = 1'b1;
						run.status     = ST_TOO_LONG;
						run.has_power  = present_q;
						run.quality    = qual_q;
						run.attention  = att_q;
						run.meditation = med_q;
					end
				end else if (pos_q <= len_q) begin
					// payload byte
					sum_d = sum_q + b;
					unique case (phase_q)
						PH_QUAL: begin
							sh_scal_d[0] = b;
							sh_seen_d[0] = 1'b1;
							phase_d = PH_CODE;
						end
						PH_ATT: begin
							sh_scal_d[1] = b;
							sh_seen_d[1] = 1'b1;
							phase_d = PH_CODE;
						end
						PH_MED: begin
							sh_scal_d[2] = b;
							sh_seen_d[2] = 1'b1;
							phase_d = PH_CODE;
						end
						PH_PLEN: begin
							band_d  = '0;
							sub_d   = 2'd0;
							phase_d = PH_PDATA;
						end
						PH_PDATA: begin
							// big-endian shift into the current band
							for (int j = 0; j < POWER_BANDS; j++) begin
								if (band_q == BAND_W'(j)) begin
									sh_pow_d[j] = (sub_q == 2'd0) ? {16'd0, b}
										: {sh_pow_q[j][15:0], b};
								end
							end
							if (sub_q == 2'd2) begin
								sub_d = 2'd0;
								if (band_q == BAND_W'(POWER_BANDS - 1)) begin
									sh_pseen_d = 1'b1;
									phase_d    = PH_CODE;
								end else begin
									band_d = band_q + 1'b1;
								end
							end else begin
								sub_d = sub_q + 1'b1;
							end
						end
						PH_SKIP: begin
							if (sub_q == 2'd2) begin
								phase_d = PH_CODE;
							end else begin
								sub_d = sub_q + 1'b1;
							end
						end
						default: begin
							if (b == CODE_QUAL) begin
								phase_d = PH_QUAL;
							end else if (b == CODE_ATT) begin
								phase_d = PH_ATT;
							end else if (b == CODE_MED) begin
								phase_d = PH_MED;
							end else if (b == CODE_POWER) begin
								sh_pseen_d = 1'b0;
								phase_d    = PH_PLEN;
							end else if (b == CODE_SKIP) begin
								sub_d   = 2'd0;
								phase_d = PH_SKIP;
							end else begin
								err_d   = 1'b1;
								phase_d = PH_CODE;
							end
						end
					endcase
				end else begin
					// checksum byte
					run.valid = 1'b1;
					if (b == ~sum_q) begin
						if (sh_seen_q[0]) qual_d = sh_scal_q[0];
						if (sh_seen_q[1]) att_d  = sh_scal_q[1];
						if (sh_seen_q[2]) med_d  = sh_scal_q[2];
						present_d = sh_pseen_q;
						for (int j = 0; j < POWER_BANDS; j++) begin
							pow_d[j] = sh_pseen_q ? sh_pow_q[j] : '0;
						end
						run.status     = err_q ? ST_UNKNOWN : ST_GOOD;
						run.has_power  = sh_pseen_q;
						run.quality    = qual_d;
						run.attention  = att_d;
						run.meditation = med_d;
						run.power0     = pow_d[0];
					end else begin
						run.status     = ST_BAD_SUM;
						run.has_power  = present_q;
						run.quality    = qual_q;
						run.attention  = att_q;
						run.meditation = med_q;
					end
					in_frame_d = 1'b0;
				end
				pos_d = pos_q + 8'd1;
			end

			// sync pair opens a frame
			if (b == SYNC_BYTE && prev_q == SYNC_BYTE && !in_frame_d) begin
				in_frame_d = 1'b1;
				pos_d      = 8'd0;
				sum_d      = 8'd0;
			end
			prev_d = b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			prev_q     <= 8'd0;
			pos_q      <= 8'd0;
			len_q      <= 8'd0;
			sum_q      <= 8'd0;
			phase_q    <= PH_CODE;
			band_q     <= '0;
			sub_q      <= 2'd0;
			for (int j = 0; j < 3; j++) begin
				sh_scal_q[j] <= 8'd0;
			end
			sh_seen_q  <= 3'b000;
			for (int j = 0; j < POWER_BANDS; j++) begin
				sh_pow_q[j] <= '0;
				pow_q[j]    <= '0;
			end
			sh_pseen_q <= 1'b0;
			err_q      <= 1'b0;
			qual_q     <= QUAL_RESET;
			att_q      <= 8'd0;
			med_q      <= 8'd0;
			present_q  <= 1'b0;
		end else begin
			in_frame_q <= in_frame_d;
			prev_q     <= prev_d;
			pos_q      <= pos_d;
			len_q      <= len_d;
			sum_q      <= sum_d;
			phase_q    <= phase_d;
			band_q     <= band_d;
			sub_q      <= sub_d;
			sh_scal_q  <= sh_scal_d;
			sh_seen_q  <= sh_seen_d;
			sh_pow_q   <= sh_pow_d;
			sh_pseen_q <= sh_pseen_d;
			err_q      <= err_d;
			qual_q     <= qual_d;
			att_q      <= att_d;
			med_q      <= med_d;
			pow_q      <= pow_d;
			present_q  <= present_d;
		end
	end

	assign pow_cur = pow_q;

endmodule

@@ hw/rtl/eegp_burst.sv @@
// Result register of the parser: emits one status result or one result per band.
// Depends on eegp_pkg; fed by eegp_decode.
module eegp_burst #(
	parameter int POWER_BANDS = eegp_pkg::POWER_BANDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  eegp_pkg::run_t              run,
	output logic                        run_ready,
	input  logic [eegp_pkg::PWR_W-1:0]  pow_cur [POWER_BANDS],
	output logic                        out_valid,
	input  logic                        out_ready,
	output eegp_pkg::status_t           status,
	output logic [7:0]                  quality,
	output logic [7:0]                  attention,
	output logic [7:0]                  meditation,
	output logic                        has_power,
	output logic [eegp_pkg::BAND_W-1:0] band_index,
	output logic [eegp_pkg::PWR_W-1:0]  band_power,
	output logic                        last
);
	import eegp_pkg::*;

	logic              valid_q;
	status_t           status_q;
	logic [7:0]        qual_q, att_q, med_q;
	logic              hp_q;
	logic [BAND_W-1:0] band_q;
	logic [PWR_W-1:0]  power_q;
	logic              last_q;

	logic              take;
	logic [BAND_W-1:0] band_nxt;
	logic [PWR_W-1:0]  power_nxt;

	assign take      = valid_q && out_ready;
	assign run_ready = !valid_q || (out_ready && last_q);
	assign band_nxt  = band_q + 1'b1;

	// power of the next band
	always_comb begin
		power_nxt = '0;
		for (int j = 0; j < POWER_BANDS; j++) begin
			if (band_nxt == BAND_W'(j)) begin
				power_nxt = pow_cur[j];
			end
		end
	end

	// valid and band walk; too-long and bad-checksum runs are single results whatever has_power says
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			band_q  <= '0;
			last_q  <= 1'b0;
		end else if (run.valid) begin
			valid_q <= 1'b1;
			band_q  <= '0;
			last_q  <= !run.has_power || (run.status == ST_TOO_LONG)
				|| (run.status == ST_BAD_SUM) || (POWER_BANDS == 1);
		end else if (take) begin
			if (last_q) begin
				valid_q <= 1'b0;
			end else begin
				band_q <= band_nxt;
				last_q <= (band_nxt == BAND_W'(POWER_BANDS - 1));
			end
		end
	end

	// payload of the result register
	always_ff @(posedge clk) begin
		if (run.valid) begin
			status_q <= run.status;
			qual_q   <= run.quality;
			att_q    <= run.attention;
			med_q    <= run.meditation;
			hp_q     <= run.has_power;
			power_q  <= run.power0;
		end else if (take && !last_q) begin
			power_q <= power_nxt;
		end
	end

	assign out_valid  = valid_q;
	assign status     = status_q;
	assign quality    = qual_q;
	assign attention  = att_q;
	assign meditation = med_q;
	assign has_power  = hp_q;
	assign band_index = band_q;
	assign band_power = power_q;
	assign last       = last_q;

`ifndef SYNTHESIS
	// a new run never overwrites a result still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		run.valid |-> (!valid_q || (out_ready && last_q)))
		else $error("run loaded over a pending result");
	// a run without powers is a single result
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !hp_q) |-> last_q)
		else $error("status run longer than one result");
	// band walk stays inside the band count
	a_band_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (band_q <= BAND_W'(POWER_BANDS - 1)))
		else $error("band index out of range");
	// final band carries last
	a_last_band: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && hp_q && band_q == BAND_W'(POWER_BANDS - 1)) |-> last_q)
		else $error("last missing on final band");
`endif

endmodule

@@ hw/rtl/eeg_headset_packet_parser_unit.sv @@
// Top level of the headset packet parser: byte stream in, result stream out.
// Depends on eegp_pkg, eegp_decode and eegp_burst.
//
// Usage:
// - Slave channel s_*: one serial byte per request in s_tdata[7:0].
// - Master channel m_*: result requests. A frame end gives one status result,
//   or POWER_BANDS results (one per band, band_index 0 up) when the committed
//   packet carried band powers; m_tlast marks the final result of the run.
// - Result path: a frame-ending byte goes through the input register, then
//   loads the result register once that register is free.
// - Throughput: one byte per cycle. A frame-ending byte is held in the input
//   register while the result register still has an earlier run to deliver,
//   so the byte rate drops only when a frame ends before the earlier run has
//   drained: a band run delivers one result per band, and takes longer
//   behind a stalled receiver; all other bytes pass at full rate.
// - m_tready low holds the current result stable; the input register then
//   fills and s_tready falls once a frame-ending byte reaches it.
// - Reset (arst_n low) clears framing, shadow and committed values; signal
//   quality reads 200, all other values 0, and no result is pending.
module eeg_headset_packet_parser_unit #(
	parameter int MAX_PAYLOAD = eegp_pkg::MAX_PAYLOAD_DEF,
	parameter int POWER_BANDS = eegp_pkg::POWER_BANDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] status, [9:2] signal_quality, [17:10] attention, [25:18] meditation,
	// [26] has_power, [29:27] band_index, [53:30] band_power, [55:54] zero
	output logic [55:0] m_tdata,
	output logic        m_tlast
);
	import eegp_pkg::*;

	run_t              run;
	logic              run_ready;
	logic [PWR_W-1:0]  pow_cur [POWER_BANDS];
	status_t           status;
	logic [7:0]        quality, attention, meditation;
	logic              has_power;
	logic [BAND_W-1:0] band_index;
	logic [PWR_W-1:0]  band_power;

	eegp_decode #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.POWER_BANDS(POWER_BANDS)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_byte   (s_tdata),
		.in_ready  (s_tready),
		.run_ready (run_ready),
		.run       (run),
		.pow_cur   (pow_cur)
	);

	eegp_burst #(
		.POWER_BANDS(POWER_BANDS)
	) u_burst (
		.clk        (clk),
		.arst_n     (arst_n),
		.run        (run),
		.run_ready  (run_ready),
		.pow_cur    (pow_cur),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.status     (status),
		.quality    (quality),
		.attention  (attention),
		.meditation (meditation),
		.has_power  (has_power),
		.band_index (band_index),
		.band_power (band_power),
		.last       (m_tlast)
	);

	// result packing, highest field first
	assign m_tdata = {2'b00, band_power, band_index, has_power,
		meditation, attention, quality, status};

endmodule

@@ test/tb_eeg_headset_packet_parser_unit.sv @@
// Self-checking testbench for the headset packet parser: drives framed byte streams
// and checks every result against a cycle-free model of the parser kept in this file.
// Depends on eegp_pkg and eeg_headset_packet_parser_unit.
module tb_eeg_headset_packet_parser_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import eegp_pkg::*;

	localparam int MAX_LEN      = MAX_PAYLOAD_DEF;
	localparam int BANDS        = POWER_BANDS_DEF;
	localparam int IDX_QUAL     = 0;
	localparam int IDX_ATT      = 1;
	localparam int IDX_MED      = 2;
	localparam int LONG_HOLD    = 400;
	localparam int TAIL_CYCLES  = 20;
	localparam int LIMIT_CYCLES = 200000;

	typedef enum {RX_FULL, RX_HALF, RX_SLOW, RX_TOGGLE} rx_mode_t;

	typedef struct {
		logic [7:0] data;
		bit         wait_drain;   // hold this byte back until all results are in
	} stream_item_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  quality;
		logic [7:0]  attention;
		logic [7:0]  meditation;
		logic        has_power;
		logic [2:0]  band;
		logic [23:0] power;
		logic        last;
	} parser_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [1:0] status, [9:2] signal_quality, [17:10] attention, [25:18] meditation,
	// [26] has_power, [29:27] band_index, [53:30] band_power, [55:54] zero
	logic [55:0] m_tdata;
	logic        m_tlast;

	eeg_headset_packet_parser_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Stimulus and scoreboard storage
	stream_item_t   pending_bytes[$];
	logic [7:0]     frame_body[$];
	parser_result_t awaited_results[$];
	bit             drained = 1'b1;
	int             frames_built = 0;
	int             bytes_accepted = 0;
	int             results_seen = 0;
	int             power_results = 0;
	int             mismatches = 0;
	int             cycle_count = 0;

	// Parser model state
	logic        frame_open;
	logic [7:0]  prev_byte_seen;
	logic [7:0]  frame_pos;
	logic [7:0]  frame_len;
	logic [7:0]  frame_sum;
	phase_t      dec_phase;
	logic [4:0]  dec_left;
	logic [7:0]  shadow_val [3];
	logic [2:0]  shadow_seen;
	logic [23:0] shadow_pwr [BANDS];
	logic        shadow_pwr_seen;
	logic        dec_err;
	logic [7:0]  cur_quality;
	logic [7:0]  cur_attention;
	logic [7:0]  cur_meditation;
	logic [23:0] cur_power [BANDS];
	logic        cur_has_power;

	// Result row built from the committed values
	function automatic void queue_result(status_t st, int band, logic [23:0] pw, bit lst);
		parser_result_t r;
		r.status     = st;
		r.quality    = cur_quality;
		r.attention  = cur_attention;
		r.meditation = cur_meditation;
		r.has_power  = cur_has_power;
		r.band       = band[2:0];
		r.power      = pw;
		r.last       = lst;
		awaited_results.push_back(r);
	endfunction

	// One payload byte into the shadow values
	function automatic void decode_payload_byte(logic [7:0] b);
		int done_bytes;
		int band;
		case (dec_phase)
		PH_QUAL: begin
			shadow_val[IDX_QUAL] = b;
			shadow_seen[IDX_QUAL] = 1'b1;
			dec_phase = PH_CODE;
		end
		PH_ATT: begin
			shadow_val[IDX_ATT] = b;
			shadow_seen[IDX_ATT] = 1'b1;
			dec_phase = PH_CODE;
		end
		PH_MED: begin
			shadow_val[IDX_MED] = b;
			shadow_seen[IDX_MED] = 1'b1;
			dec_phase = PH_CODE;
		end
		PH_PLEN: begin
			dec_left = 5'(3 * BANDS);
			dec_phase = PH_PDATA;
		end
		PH_PDATA: begin
			done_bytes = 3 * BANDS - dec_left;
			band = done_bytes / 3;
			if (band < BANDS) begin
				if (done_bytes % 3 == 0)
					shadow_pwr[band] = {16'h0000, b};
				else
					shadow_pwr[band] = {shadow_pwr[band][15:0], b};
			end
			dec_left = dec_left - 5'd1;
			if (dec_left == 5'd0) begin
				shadow_pwr_seen = 1'b1;
				dec_phase = PH_CODE;
			end
		end
		PH_SKIP: begin
			dec_left = dec_left - 5'd1;
			if (dec_left == 5'd0)
				dec_phase = PH_CODE;
		end
		default: begin
			case (b)
			CODE_QUAL: dec_phase = PH_QUAL;
			CODE_ATT:  dec_phase = PH_ATT;
			CODE_MED:  dec_phase = PH_MED;
			CODE_POWER: begin
				shadow_pwr_seen = 1'b0;
				dec_phase = PH_PLEN;
			end
			CODE_SKIP: begin
				dec_left = 5'd3;
				dec_phase = PH_SKIP;
			end
			default: begin
				dec_err = 1'b1;
				dec_phase = PH_CODE;
			end
			endcase
		end
		endcase
	endfunction

	// Framing: length, payload, checksum and commit for one accepted byte
	function automatic void advance_frame_parser(logic [7:0] b);
		logic [7:0] want_sum;
		status_t    run_status;
		if (frame_open) begin
			if (frame_pos == 8'd0) begin
				frame_len = b;
				frame_sum = 8'h00;
				dec_phase = PH_CODE;
				dec_left = 5'd0;
				shadow_seen = 3'b000;
				shadow_pwr_seen = 1'b0;
				dec_err = 1'b0;
				if (frame_len > MAX_LEN) begin
					frame_open = 1'b0;
					queue_result(ST_TOO_LONG, 0, 24'h0, 1'b1);
				end
			end else if (frame_pos <= frame_len) begin
				frame_sum = frame_sum + b;
				decode_payload_byte(b);
			end else begin
				want_sum = ~frame_sum;
				if (b == want_sum) begin
					if (shadow_seen[IDX_QUAL]) cur_quality = shadow_val[IDX_QUAL];
					if (shadow_seen[IDX_ATT]) cur_attention = shadow_val[IDX_ATT];
					if (shadow_seen[IDX_MED]) cur_meditation = shadow_val[IDX_MED];
					cur_has_power = shadow_pwr_seen;
					for (int j = 0; j < BANDS; j++)
						cur_power[j] = cur_has_power ? shadow_pwr[j] : 24'h0;
					run_status = dec_err ? ST_UNKNOWN : ST_GOOD;
					if (cur_has_power) begin
						for (int j = 0; j < BANDS; j++)
							queue_result(run_status, j, cur_power[j], j == BANDS - 1);
					end else begin
						queue_result(run_status, 0, 24'h0, 1'b1);
					end
				end else begin
					queue_result(ST_BAD_SUM, 0, 24'h0, 1'b1);
				end
				frame_open = 1'b0;
			end
			frame_pos = frame_pos + 8'd1;
		end
		// sync pair outside a frame, including on the byte that just closed one
		if (b == SYNC_BYTE && prev_byte_seen == SYNC_BYTE && !frame_open) begin
			frame_open = 1'b1;
			frame_pos = 8'd0;
			frame_sum = 8'h00;
		end
		prev_byte_seen = b;
	endfunction

	// Stimulus builders
	function automatic void put_stream(logic [7:0] b, bit wait_drain);
		stream_item_t it;
		it.data = b;
		it.wait_drain = wait_drain;
		pending_bytes.push_back(it);
	endfunction

	function automatic void add_scalar(logic [7:0] code, logic [7:0] value);
		frame_body.push_back(code);
		frame_body.push_back(value);
	endfunction

	// Power block; fewer than 3*BANDS data bytes leaves it cut short
	function automatic void add_power(int data_bytes, bit extremes);
		frame_body.push_back(CODE_POWER);
		frame_body.push_back(8'($urandom));
		for (int k = 0; k < data_bytes; k++) begin
			if (extremes)
				frame_body.push_back(((k / 3) % 2 == 0) ? 8'hFF : 8'h00);
			else
				frame_body.push_back(8'($urandom));
		end
	endfunction

	// Sync pair, length, body and checksum (good or corrupted)
	function automatic void emit_frame(bit bad_sum, bit wait_drain);
		logic [7:0] sum;
		sum = 8'h00;
		put_stream(SYNC_BYTE, wait_drain);
		put_stream(SYNC_BYTE, 1'b0);
		put_stream(8'(frame_body.size()), 1'b0);
		foreach (frame_body[k]) begin
			sum = sum + frame_body[k];
			put_stream(frame_body[k], 1'b0);
		end
		if (bad_sum)
			put_stream(~sum ^ 8'($urandom_range(1, 255)), 1'b0);
		else
			put_stream(~sum, 1'b0);
		frame_body.delete();
		frames_built++;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Driver: bursts with random gaps, model updated on every accepted request
	int           burst_left;
	int           gap_left;
	bit           send_now;
	stream_item_t next_item;

	always @(negedge clk) begin
		drained = (awaited_results.size() == 0);
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			burst_left = $urandom_range(1, 40);
			gap_left = 0;
			frame_open = 1'b0;
			prev_byte_seen = 8'h00;
			frame_pos = 8'h00;
			frame_len = 8'h00;
			frame_sum = 8'h00;
			dec_phase = PH_CODE;
			dec_left = 5'd0;
			shadow_seen = 3'b000;
			shadow_pwr_seen = 1'b0;
			dec_err = 1'b0;
			cur_quality = QUAL_RESET;
			cur_attention = 8'h00;
			cur_meditation = 8'h00;
			cur_has_power = 1'b0;
			foreach (shadow_val[k]) shadow_val[k] = 8'h00;
			for (int j = 0; j < BANDS; j++) begin
				shadow_pwr[j] = 24'h0;
				cur_power[j] = 24'h0;
			end
		end else begin
			if (s_tvalid && s_tready) begin
				advance_frame_parser(s_tdata);
				bytes_accepted++;
			end
			if (!(s_tvalid && !s_tready)) begin
				send_now = 1'b0;
				if (gap_left > 0)
					gap_left--;
				else if (pending_bytes.size() != 0 && (!pending_bytes[0].wait_drain
						|| (drained && awaited_results.size() == 0)))
					send_now = 1'b1;
				if (send_now) begin
					next_item = pending_bytes.pop_front();
					s_tdata <= next_item.data;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						case ($urandom_range(0, 9))
						0, 1, 2: gap_left = 0;
						9:       gap_left = $urandom_range(4, 15);
						default: gap_left = $urandom_range(1, 3);
						endcase
					end
				end
				s_tvalid <= send_now;
			end
		end
	end

	// Monitor: checks each result request, drives the receiver stall pattern
	parser_result_t want;
	rx_mode_t       rx_mode;
	int             mode_left;
	int             hold_left;
	bit             long_hold_done = 1'b0;
	logic           rx_ready;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_mode = RX_FULL;
			mode_left = 0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, tdata %h tlast %b",
						$time, m_tdata, m_tlast);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					check_field("status", want.status, m_tdata[1:0]);
					check_field("signal_quality", want.quality, m_tdata[9:2]);
					check_field("attention", want.attention, m_tdata[17:10]);
					check_field("meditation", want.meditation, m_tdata[25:18]);
					check_field("has_power", want.has_power, m_tdata[26]);
					check_field("band_index", want.band, m_tdata[29:27]);
					check_field("band_power", want.power, m_tdata[53:30]);
					check_field("last", want.last, m_tlast);
					if (want.has_power)
						power_results++;
				end
			end
			// one long hold-off so the input side backs up
			if (hold_left > 0) begin
				hold_left--;
				rx_ready = 1'b0;
			end else if (!long_hold_done && results_seen >= 12) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				rx_ready = 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(8, 64);
				end else begin
					mode_left--;
				end
				case (rx_mode)
				RX_FULL: rx_ready = 1'b1;
				RX_HALF: rx_ready = 1'($urandom_range(0, 1));
				RX_SLOW: rx_ready = ($urandom_range(0, 3) == 0);
				default: rx_ready = ~m_tready;
				endcase
			end
			m_tready <= rx_ready;
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: timeout after %0d cycles, %0d bytes and %0d results outstanding",
				$time, cycle_count, pending_bytes.size(), awaited_results.size());
			$display("** eeg_headset_packet_parser_unit: FAILED **");
			$finish;
		end
	end

	// Stimulus: directed frames, then random traffic; end of run
	int         directed_bytes;
	int         directed_frames;
	int         kind;
	int         fields;
	bit         hold;
	logic [7:0] unk;

	initial begin
		// empty payload, reset values reported
		emit_frame(1'b0, 1'b0);
		// scalar extremes
		add_scalar(CODE_QUAL, 8'h00);
		add_scalar(CODE_ATT, 8'hFF);
		add_scalar(CODE_MED, 8'h5A);
		emit_frame(1'b0, 1'b0);
		// bad checksum leaves values alone
		add_scalar(CODE_QUAL, 8'h11);
		emit_frame(1'b1, 1'b0);
		// length one above the maximum, and the largest length
		put_stream(SYNC_BYTE, 1'b0);
		put_stream(SYNC_BYTE, 1'b0);
		put_stream(8'(MAX_LEN + 1), 1'b0);
		put_stream(SYNC_BYTE, 1'b0);
		put_stream(SYNC_BYTE, 1'b0);
		put_stream(8'hFF, 1'b0);
		frames_built += 2;
		// full-length payload: all scalars plus a complete power block
		add_scalar(CODE_QUAL, 8'hFF);
		add_scalar(CODE_ATT, 8'h00);
		add_scalar(CODE_MED, 8'hA5);
		add_power(3 * BANDS, 1'b1);
		emit_frame(1'b0, 1'b0);
		// unknown code, still committed; powers drop out
		frame_body.push_back(8'hFF);
		add_scalar(CODE_MED, 8'h77);
		emit_frame(1'b0, 1'b0);
		// skip block hiding a sync pair, then a value cut off by the payload end
		frame_body.push_back(CODE_SKIP);
		frame_body.push_back(SYNC_BYTE);
		frame_body.push_back(SYNC_BYTE);
		frame_body.push_back(8'h00);
		add_scalar(CODE_ATT, 8'h99);
		frame_body.push_back(CODE_QUAL);
		emit_frame(1'b0, 1'b0);
		// repeated code, last value wins
		add_scalar(CODE_ATT, 8'h01);
		add_scalar(CODE_ATT, 8'h02);
		emit_frame(1'b0, 1'b0);
		// power block cut short
		add_scalar(CODE_QUAL, 8'h33);
		add_power(10, 1'b0);
		emit_frame(1'b0, 1'b0);
		// checksum 0xAA after a 0xAA payload byte opens the next frame at once
		frame_body.push_back(CODE_SKIP);
		frame_body.push_back(8'h00);
		frame_body.push_back(8'h55 - CODE_SKIP - SYNC_BYTE);
		frame_body.push_back(SYNC_BYTE);
		emit_frame(1'b0, 1'b0);
		put_stream(8'h00, 1'b0);
		put_stream(8'hFF, 1'b0);
		frames_built++;
		// three sync bytes: the third is read as a length too long
		put_stream(SYNC_BYTE, 1'b0);
		put_stream(SYNC_BYTE, 1'b0);
		put_stream(SYNC_BYTE, 1'b0);
		put_stream(8'h00, 1'b0);
		frames_built++;
		// sender waits for every result before this frame
		add_scalar(CODE_MED, 8'h3C);
		emit_frame(1'b0, 1'b1);
		directed_bytes = pending_bytes.size();
		directed_frames = frames_built;

		// random traffic, mostly well-formed frames
		while (pending_bytes.size() < directed_bytes + 20
				|| frames_built < directed_frames + 2) begin
			kind = $urandom_range(0, 99);
			hold = (frames_built % 12 == 0);
			if (kind < 35) begin
				fields = $urandom_range(0, 6);
				repeat (fields) begin
					case ($urandom_range(0, 9))
					0, 1: add_scalar(CODE_QUAL, 8'($urandom));
					2, 3: add_scalar(CODE_ATT, 8'($urandom));
					4, 5: add_scalar(CODE_MED, 8'($urandom));
					6, 7: begin
						frame_body.push_back(CODE_SKIP);
						repeat (3) frame_body.push_back(8'($urandom));
					end
					8: begin
						do
							unk = 8'($urandom);
						while (unk == CODE_QUAL || unk == CODE_ATT || unk == CODE_MED
							|| unk == CODE_POWER || unk == CODE_SKIP);
						frame_body.push_back(unk);
					end
					default: frame_body.push_back(CODE_MED);
					endcase
				end
				emit_frame(1'b0, hold);
			end else if (kind < 65) begin
				if ($urandom_range(0, 1)) add_scalar(CODE_QUAL, 8'($urandom));
				if ($urandom_range(0, 1)) add_scalar(CODE_ATT, 8'($urandom));
				if ($urandom_range(0, 1)) add_scalar(CODE_MED, 8'($urandom));
				if ($urandom_range(0, 9) == 0)
					add_power($urandom_range(0, 3 * BANDS - 1), 1'b0);
				else
					add_power(3 * BANDS, 1'b0);
				emit_frame(1'b0, hold);
			end else if (kind < 75) begin
				add_scalar(CODE_QUAL, 8'($urandom));
				if ($urandom_range(0, 1)) add_power(3 * BANDS, 1'b0);
				emit_frame(1'b1, hold);
			end else if (kind < 83) begin
				put_stream(SYNC_BYTE, hold);
				put_stream(SYNC_BYTE, 1'b0);
				put_stream(8'($urandom_range(MAX_LEN + 1, 255)), 1'b0);
				frames_built++;
			end else if (kind < 93) begin
				repeat ($urandom_range(0, MAX_LEN)) frame_body.push_back(8'($urandom));
				emit_frame($urandom_range(0, 3) == 0, hold);
			end else begin
				repeat ($urandom_range(1, 4)) put_stream(8'($urandom), 1'b0);
			end
		end

		wait (arst_n);
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || s_tvalid || awaited_results.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Run: %0d frames over %0d bytes, %0d results checked (%0d in band-power runs)",
			frames_built, bytes_accepted, results_seen, power_results);
		$display("Field mismatches and stray results: %0d", mismatches);
		if (mismatches == 0) begin
			$display("** eeg_headset_packet_parser_unit: PASSED **");
		end else begin
			$display("** eeg_headset_packet_parser_unit: FAILED **");
		end
		$finish;
	end

endmodule

@@ eeg_headset_packet_parser_unit.f @@
hw/rtl/eegp_pkg.sv
hw/rtl/eegp_decode.sv
hw/rtl/eegp_burst.sv
hw/rtl/eeg_headset_packet_parser_unit.sv
test/tb_eeg_headset_packet_parser_unit.sv
